>>> sv/url_percent_decoder_macros.svh
// assertion macros for the url percent decoder
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define UPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

>>> sv/upd_pkg.sv
// shared types, constants and helpers for the url percent decoder
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // most output beats one input byte can cause
  localparam int MAX_BEATS = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // what the front holds between input beats
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // the decoded beats caused by one input byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_BEATS-1:0][7:0]  beats;
    logic                       last;
  } upd_group_t;

  typedef struct packed {
    logic  push;
    pend_t pend;
  } upd_front_stat_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> sv/upd_queue.sv
// short group queue between the front and the back
`default_nettype none

module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire upd_pkg::upd_group_t wr_data,
  input  wire logic               rd_en,
  output      upd_pkg::upd_group_t rd_data,
  output      logic               full,
  output      logic               empty
);
  import upd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upd_group_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/upd_front.sv
// front: tracks held escape bytes and builds the beat group for each input byte
`default_nettype none

module upd_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic [7:0]              in_byte,
  input  wire logic                    end_of_string,
  input  wire logic                    plus_as_space,
  output      upd_pkg::upd_group_t     grp,
  output      upd_pkg::upd_front_stat_t stat
);
  import upd_pkg::*;

  pend_t      pend;
  pend_t      pend_feed;
  pend_t      pend_next;
  logic [7:0] digit;
  hex_t       hx;
  hex_t       hx_held;
  logic       is_pct;
  logic [7:0] mapped;

  assign hx      = hex_decode(in_byte);
  assign hx_held = hex_decode(digit);
  assign is_pct  = (in_byte == PCT_CHAR);
  assign mapped  = (plus_as_space && in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;

  // next state
  always_comb begin
    case (pend)
      PEND_NONE: begin
        pend_feed = is_pct ? PEND_PCT : PEND_NONE;
      end
      PEND_PCT: begin
        pend_feed = hx.ok ? PEND_DIGIT : (is_pct ? PEND_PCT : PEND_NONE);
      end
      default: begin
        pend_feed = hx.ok ? PEND_NONE : (is_pct ? PEND_PCT : PEND_NONE);
      end
    endcase
    pend_next = end_of_string ? PEND_NONE : pend_feed;
  end

  // outputs: append beats in order
  always_comb begin
    logic [1:0]                n;
    logic [MAX_BEATS-1:0][7:0] beats;
    n     = 2'd0;
    beats = '0;
    case (pend)
      PEND_NONE: begin
        if (!is_pct) begin
          beats[n] = mapped;
          n        = n + 2'd1;
        end
      end
      PEND_PCT: begin
        if (!hx.ok) begin
          beats[n] = PCT_CHAR;
          n        = n + 2'd1;
          if (!is_pct) begin
            beats[n] = mapped;
            n        = n + 2'd1;
          end
        end
      end
      default: begin
        if (hx.ok) begin
          beats[n] = {hx_held.val, hx.val};
          n        = n + 2'd1;
        end else begin
          beats[n] = PCT_CHAR;
          n        = n + 2'd1;
          beats[n] = digit;
          n        = n + 2'd1;
          if (!is_pct) begin
            beats[n] = mapped;
            n        = n + 2'd1;
          end
        end
      end
    endcase
    // end of string: flush what is still held
    if (end_of_string && pend_feed != PEND_NONE) begin
      beats[n] = PCT_CHAR;
      n        = n + 2'd1;
      if (pend_feed == PEND_DIGIT) begin
        beats[n] = in_byte;
        n        = n + 2'd1;
      end
    end
    grp.cnt   = n;
    grp.beats = beats;
    grp.last  = end_of_string;
  end

  assign stat.push = accept && (grp.cnt != 2'd0);
  assign stat.pend = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pend == PEND_PCT && hx.ok) begin
      digit <= in_byte;
    end
  end

endmodule

`default_nettype wire

>>> sv/upd_back.sv
// back: takes groups off the queue and hands out their beats one at a time
`default_nettype none

module upd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire upd_pkg::upd_group_t q_data,
  input  wire logic                q_empty,
  output      logic                q_pop,
  input  wire logic                pop,
  output      logic                empty,
  output      logic [7:0]          out_byte,
  output      logic                out_last
);
  import upd_pkg::*;

  upd_group_t grp;
  logic       valid;
  logic [1:0] pos;
  logic [1:0] last_idx;
  logic       done_beat;
  logic       load;

  assign last_idx  = grp.cnt - 2'd1;
  assign done_beat = valid && pop && (pos == last_idx);
  assign load      = (!valid || done_beat) && !q_empty;
  assign q_pop     = load;

  assign empty    = !valid;
  assign out_byte = grp.beats[pos];
  assign out_last = grp.last && (pos == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      pos   <= 2'd0;
    end else if (done_beat) begin
      valid <= 1'b0;
    end else if (valid && pop) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= q_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/url_percent_decoder.sv
// top level of the streaming url percent decoder
//
//  channel   direction  handshake            payload
//  input     in         push / full          in_byte, end_of_string
//  result    out        empty / pop          out_byte, out_last
//  config    in         cfg_we               cfg_wdata (plus_as_space)
//
// one input beat is taken per cycle while the group queue has room
// each input byte yields zero to three result beats; the back hands out one result
// beat per cycle on pop, so bytes with several results cost extra cycles there
// the first result beat of an input beat passes through the group queue and then
// the back's group register before it shows on the ports, and can be popped there
// rst is synchronous and clears held escape state, the queue and the back;
// plus_as_space comes out of reset set
// a stalled result side fills the queue, then full rises and input stops
`default_nettype none
`include "url_percent_decoder_macros.svh"

module url_percent_decoder #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output      logic       full,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [7:0] out_byte,
  output      logic       out_last,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata
);
  import upd_pkg::*;

  // mode register: plus sign decodes to space when set
  logic plus_as_space;

  logic            accept;
  upd_group_t      grp;
  upd_front_stat_t fstat;
  upd_group_t      q_data;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b1;
    end else if (cfg_we) begin
      plus_as_space <= cfg_wdata;
    end
  end

  // the front only stalls on a full group queue
  assign full   = q_full;
  assign accept = push && !q_full;

  upd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .plus_as_space (plus_as_space),
    .grp           (grp),
    .stat          (fstat)
  );

  // groups with no beats (a held percent sign or held digit) never enter the queue
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fstat.push),
    .wr_data (grp),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back side: serializes one group at a time onto the result ports
  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // end of string always leaves nothing held
  `UPD_ASSERT_NEXT(a_eos_clears, accept && end_of_string, fstat.pend == PEND_NONE)
  // end of string always produces a group
  `UPD_ASSERT_IMPL(a_eos_pushes, accept && end_of_string, fstat.push)
  // a pushed group carries at least one beat
  `UPD_ASSERT_IMPL(a_grp_cnt, fstat.push, grp.cnt != 2'd0)

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for url_percent_decoder: queued stimulus, predictor, result checker
`default_nettype none

module testbench;
  import upd_pkg::*;

  // quiet cycles with no beat on either side before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // cycles allowed after the last result before a config write or the end
  localparam int SETTLE_WAIT  = 10;
  // length of the deliberate result-side hold that backs up the block
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic [7:0] dat;
    logic       eos;
  } raw_beat_t;

  typedef struct {
    logic [7:0] dat;
    logic       last;
  } decoded_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  // encoded bytes waiting to be offered, oldest first
  raw_beat_t     encoded_q[$];
  // decoded beats the block still owes, oldest first
  decoded_beat_t decoded_q[$];

  // predictor copy of the block state
  logic       plus_mode = 1'b1;
  pend_t      held_state = PEND_NONE;
  logic [7:0] held_digit = 8'h00;

  int  err_count = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  // sender and receiver idling state
  int  tx_gap = 0;
  int  tx_calm = 0;
  int  rx_gap = 0;
  int  rx_calm = 0;
  int  hold_left = 0;

  always #4 clk = ~clk;

  url_percent_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // {valid, nibble} for an ascii hex digit of either case
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      return {1'b1, d[3:0]};
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  task automatic owe_beat(input logic [7:0] b);
    decoded_q.push_back('{b, 1'b0});
  endtask

  // a byte seen with nothing held: plus maps to space when enabled,
  // percent opens an escape, anything else passes through
  task automatic plain_byte(input logic [7:0] b);
    if (plus_mode && b == PLUS_CHAR) begin
      owe_beat(SPACE_CHAR);
    end else if (b == PCT_CHAR) begin
      held_state = PEND_PCT;
    end else begin
      owe_beat(b);
    end
  endtask

  // works out every decoded beat caused by one accepted encoded byte
  task automatic decode_step(input logic [7:0] b, input logic eos);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] digit;
    int         owed_before;
    owed_before = decoded_q.size();
    lo = hex_digit_value(b);
    case (held_state)
      PEND_NONE: begin
        plain_byte(b);
      end
      PEND_PCT: begin
        if (lo[4]) begin
          held_digit = b;
          held_state = PEND_DIGIT;
        end else begin
          // bad escape on the first digit: percent goes out, byte is redone
          owe_beat(PCT_CHAR);
          held_state = PEND_NONE;
          plain_byte(b);
        end
      end
      default: begin
        if (lo[4]) begin
          hi = hex_digit_value(held_digit);
          owe_beat({hi[3:0], lo[3:0]});
          held_state = PEND_NONE;
        end else begin
          // bad escape on the second digit: percent goes out, held digit and byte are redone
          digit = held_digit;
          owe_beat(PCT_CHAR);
          held_state = PEND_NONE;
          plain_byte(digit);
          plain_byte(b);
        end
      end
    endcase
    if (eos) begin
      // escape cut by the end of the string goes out literally
      if (held_state != PEND_NONE) owe_beat(PCT_CHAR);
      if (held_state == PEND_DIGIT) owe_beat(held_digit);
      held_state = PEND_NONE;
      if (decoded_q.size() > owed_before) decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // sender: offers the oldest queued byte, with random gap bursts
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic offer;
    offer = !rst && encoded_q.size() > 0;
    if (offer) begin
      if (tx_gap > 0) begin
        tx_gap--;
        offer = 1'b0;
      end else if (tx_calm > 0) begin
        tx_calm--;
      end else if (!no_idle) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // no offer now, and a random gap follows
            tx_gap = $urandom_range(0, 6);
            offer = 1'b0;
          end
          2: tx_calm = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
    push <= offer;
    if (offer) begin
      in_byte       <= encoded_q[0].dat;
      end_of_string <= encoded_q[0].eos;
    end
  end

  // ---------------------------------------------------------------------
  // receiver: pops with random stall bursts, plus one long hold on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic take;
    take = !rst;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      take = 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
    end else if (!no_idle) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          rx_gap = $urandom_range(0, 6);
          take = 1'b0;
        end
        2: rx_calm = $urandom_range(10, 40);
        default: ;
      endcase
    end
    pop <= take;
  end

  // ---------------------------------------------------------------------
  // monitor: predicts on each input beat, checks each result beat
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_beat_t owed;
    if (!rst) begin
      if (push && !full) begin
        decode_step(in_byte, end_of_string);
        encoded_q.delete(0);
      end
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result beat: out_byte %h out_last %b", out_byte, out_last);
          err_count++;
        end else begin
          owed = decoded_q.pop_front();
          if (out_byte !== owed.dat) begin
            $error("out_byte mismatch: expected %h, actual %h", owed.dat, out_byte);
            err_count++;
          end
          if (out_last !== owed.last) begin
            $error("out_last mismatch: expected %b, actual %b", owed.last, out_last);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog: ends a hung run
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_raw(input logic [7:0] b, input logic eos);
    encoded_q.push_back('{b, eos});
  endtask

  // one whole string, end flag on its final byte
  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      encoded_q.push_back('{s[k], k == s.len() - 1});
    end
  endtask

  function automatic logic [7:0] pick_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + (r - 10));
    return 8'("A" + (r - 16));
  endfunction

  // random strings, half well-formed escapes and pluses with random
  // content, half raw noise and broken escapes
  task automatic queue_random_text(input int n_bytes);
    logic [7:0] text[$];
    int         queued;
    int         tokens;
    queued = 0;
    while (queued < n_bytes) begin
      text.delete();
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      for (int t = 0; t < tokens; t++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            text.push_back(PCT_CHAR);
            text.push_back(pick_hex_char());
            text.push_back(pick_hex_char());
          end
          4: text.push_back(PLUS_CHAR);
          5: begin
            // broken escape: random follow-up bytes, maybe truncated
            text.push_back(PCT_CHAR);
            if ($urandom_range(0, 1)) text.push_back(pick_hex_char());
            if ($urandom_range(0, 1)) text.push_back(8'($urandom_range(0, 255)));
          end
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      for (int k = 0; k < text.size(); k++) begin
        encoded_q.push_back('{text[k], k == text.size() - 1});
      end
      queued += text.size();
    end
  endtask

  // waits until every byte is taken and every owed beat has come, then lets the block settle
  task automatic wait_drained();
    while (encoded_q.size() != 0 || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // mode register write, only ever issued while the block is drained
  task automatic write_plus_mode(input logic v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    plus_mode = v;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // directed, plus mode as it comes out of reset
    queue_text("%4a+");        // lower-case escape, plus to space
    queue_text("%zz");         // bad escape on the first digit
    queue_text("%4g");         // bad escape on the second digit
    queue_text("%");           // lone percent cut by the end
    queue_text("%f");          // percent and digit cut by the end
    queue_text("%%41");        // percent right after percent
    queue_text("%+");          // plus redone after a bad escape
    queue_text("%00%Ff");      // escape extremes, mixed case
    queue_raw(8'h00, 1'b0);    // raw byte extremes
    queue_raw(8'hFF, 1'b1);
    wait_drained();

    // plus passes through unchanged with the mode off
    write_plus_mode(1'b0);
    queue_text("a+%2+");
    queue_random_text(30);
    wait_drained();

    // long result-side hold while the sender keeps going, so full rises
    write_plus_mode(1'b1);
    hold_req = 1'b1;
    queue_random_text(30);
    wait_drained();

    write_plus_mode(1'b0);
    queue_random_text(25);
    wait_drained();

    // closing stretch at full rate on both sides
    write_plus_mode(1'b1);
    no_idle = 1'b1;
    queue_random_text(30);
    wait_drained();

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/upd_pkg.sv
sv/upd_queue.sv
sv/upd_front.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
verif/testbench.sv
